// ----- rtl/text_terminal_writer_unit_macros.svh -----
// Assertion macros for the text terminal writer checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef TEXT_TERMINAL_WRITER_UNIT_MACROS_SVH
`define TEXT_TERMINAL_WRITER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TTW_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttw: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define TTW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttw: next-cycle check failed");

`endif

// ----- rtl/ttw_pkg.sv -----
// Shared types and constants of the text terminal writer.
// No dependencies; every other file but the macro header imports this package.
`timescale 1ns / 1ps

package ttw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;
    localparam int RROW_W = 5;
    localparam int RCOL_W = 7;

    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
    // unused code: no change, answers with the cursor
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAR_W-1:0] char_code;
        logic [RROW_W-1:0] read_row;
        logic [RCOL_W-1:0] read_col;
    } ttw_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [RCOL_W-1:0] cursor_col;
        logic [RROW_W-1:0] cursor_row;
    } ttw_out_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;        // capture the accepted item
        logic next_line;    // column 0, row down or scroll
        logic col_zero;     // carriage return
        logic put_write;    // write char at cursor, column up
        logic clear_start;  // home cursor, start full sweep
        logic sweep_step;   // write one space at sweep address
        logic read;         // read one cell
        logic out_load;     // load the result register
        logic cell_sel;     // result carries the cell read
    } ttw_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic at_bottom;
        logic wrap_pending;
        logic sweep_last;
        logic out_free;
    } ttw_status_t;

endpackage

// ----- rtl/ttw_in_if.sv -----
// Input channel of the text terminal writer: valid, ready and one item.
// Depends on ttw_pkg for the item type.
`timescale 1ns / 1ps

interface ttw_in_if;
    import ttw_pkg::*;

    logic    valid;
    logic    ready;
    ttw_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/ttw_out_if.sv -----
// Result channel of the text terminal writer: valid, ready and one item.
// Depends on ttw_pkg for the item type.
`timescale 1ns / 1ps

interface ttw_out_if;
    import ttw_pkg::*;

    logic     valid;
    logic     ready;
    ttw_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/ttw_ctrl.sv -----
// Controller of the text terminal writer: sequences put, scroll, clear and read.
// Depends on ttw_pkg; drives the datapath through ttw_ctl_t.
`timescale 1ns / 1ps

module ttw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  ttw_pkg::ttw_in_t     cmd_payload,
    output logic                 cmd_ready,
    input  ttw_pkg::ttw_status_t st,
    output ttw_pkg::ttw_ctl_t    ctl
);
    import ttw_pkg::*;

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_SCROLL = 7'b0000100,
        S_CLEAR  = 7'b0001000,
        S_PUT    = 7'b0010000,
        S_READ   = 7'b0100000,
        S_RDONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   put_pend_reg, put_pend_next;   // a char write follows the scroll
    logic   accept;

    assign cmd_ready = (state_reg == S_IDLE) && st.out_free;
    assign accept    = cmd_valid && cmd_ready;

    always_comb
    begin
        ctl           = '0;
        state_next    = state_reg;
        put_pend_next = put_pend_reg;
        case (state_reg)
            S_INIT:
            begin
                ctl.sweep_step = 1'b1;
                if (st.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    ctl.latch = 1'b1;
                    case (cmd_payload.func)
                        FUNC_PUT:
                        begin
                            if (cmd_payload.char_code == CH_NEWLINE)
                            begin
                                ctl.next_line = 1'b1;
                                if (st.at_bottom)
                                begin
                                    put_pend_next = 1'b0;
                                    state_next    = S_SCROLL;
                                end
                                else
                                    ctl.out_load = 1'b1;
                            end
                            else if (cmd_payload.char_code == CH_RETURN)
                            begin
                                ctl.col_zero = 1'b1;
                                ctl.out_load = 1'b1;
                            end
                            else if (st.wrap_pending)
                            begin
                                ctl.next_line = 1'b1;
                                if (st.at_bottom)
                                begin
                                    put_pend_next = 1'b1;
                                    state_next    = S_SCROLL;
                                end
                                else
                                    state_next = S_PUT;
                            end
                            else
                                state_next = S_PUT;
                        end
                        FUNC_CLEAR:
                        begin
                            ctl.clear_start = 1'b1;
                            state_next      = S_CLEAR;
                        end
                        FUNC_READ:
                            state_next = S_READ;
                        default:
                            ctl.out_load = 1'b1;   // unused code: cursor only
                    endcase
                end
            end
            S_SCROLL:
            begin
                ctl.sweep_step = 1'b1;
                if (st.sweep_last)
                begin
                    if (put_pend_reg)
                        state_next = S_PUT;
                    else
                    begin
                        ctl.out_load = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            S_CLEAR:
            begin
                ctl.sweep_step = 1'b1;
                if (st.sweep_last)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_PUT:
            begin
                ctl.put_write = 1'b1;
                ctl.out_load  = 1'b1;
                state_next    = S_IDLE;
            end
            S_READ:
            begin
                ctl.read   = 1'b1;
                state_next = S_RDONE;
            end
            S_RDONE:
            begin
                ctl.out_load = 1'b1;
                ctl.cell_sel = 1'b1;
                state_next   = S_IDLE;
            end
            default:
                state_next = S_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            put_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            put_pend_reg <= put_pend_next;
        end
    end

endmodule

// ----- rtl/ttw_datapath.sv -----
// Datapath of the text terminal writer: cursor, scroll offset, sweep counter,
// screen memory and result register. Depends on ttw_pkg and ttw_out_if.
`timescale 1ns / 1ps

module ttw_datapath #(
    parameter int COLUMNS = ttw_pkg::DEF_COLUMNS,
    parameter int ROWS    = ttw_pkg::DEF_ROWS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ttw_pkg::ttw_in_t     cmd_payload,
    input  ttw_pkg::ttw_ctl_t    ctl,
    output ttw_pkg::ttw_status_t st,
    ttw_out_if.source            resp
);
    import ttw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS + 1);   // column incl. wrap pending
    localparam int CXW   = $clog2(COLUMNS);       // column index
    localparam int RW    = $clog2(ROWS);

    localparam logic [RW:0]   ROWS_X    = (RW+1)'(ROWS);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] COLS_C    = CW'(COLUMNS);
    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [AW-1:0] ROW_SPAN  = AW'(COLUMNS - 1);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [RW-1:0]     top_reg, top_next;     // physical row shown on top
    logic [AW-1:0]     sweep_addr_reg, sweep_addr_next;
    logic [AW-1:0]     sweep_end_reg, sweep_end_next;
    logic [CHAR_W-1:0] char_reg;
    logic [RW-1:0]     rd_row_reg;
    logic [CXW-1:0]    rd_col_reg;
    logic              in_range_reg;
    logic [CHAR_W-1:0] rd_data_reg;
    logic              out_valid_reg, out_valid_next;
    ttw_out_t          out_item_reg;

    logic [CHAR_W-1:0] mem [CELLS];

    logic [RW-1:0]     row_sel, phys_row;
    logic [CXW-1:0]    col_sel;
    logic [RW:0]       phys_sum;
    logic [AW-1:0]     top_base, cell_addr, mem_addr;
    logic              mem_we;
    logic [CHAR_W-1:0] mem_wdata;

    assign st.at_bottom    = (row_reg == LAST_ROW);
    assign st.wrap_pending = (col_reg == COLS_C);
    assign st.sweep_last   = (sweep_addr_reg == sweep_end_reg);
    assign st.out_free     = !out_valid_reg || resp.ready;

    // logical row -> physical row through the scroll offset
    assign row_sel   = ctl.read ? rd_row_reg : row_reg;
    assign col_sel   = ctl.read ? rd_col_reg : col_reg[CXW-1:0];
    assign phys_sum  = {1'b0, top_reg} + {1'b0, row_sel};
    assign phys_row  = (phys_sum >= ROWS_X) ? RW'(phys_sum - ROWS_X) : phys_sum[RW-1:0];
    assign cell_addr = AW'(phys_row) * COLS_A + AW'(col_sel);
    assign top_base  = AW'(top_reg) * COLS_A;

    assign mem_addr  = ctl.sweep_step ? sweep_addr_reg : cell_addr;
    assign mem_we    = ctl.sweep_step || ctl.put_write;
    assign mem_wdata = ctl.sweep_step ? CH_SPACE : char_reg;

    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        top_next        = top_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_end_next  = sweep_end_reg;
        if (ctl.clear_start)
        begin
            col_next        = '0;
            row_next        = '0;
            top_next        = '0;
            sweep_addr_next = '0;
            sweep_end_next  = LAST_CELL;
        end
        else if (ctl.next_line)
        begin
            col_next = '0;
            if (row_reg == LAST_ROW)
            begin
                // old top row becomes the blank bottom row
                top_next        = (top_reg == LAST_ROW) ? '0 : top_reg + RW'(1);
                sweep_addr_next = top_base;
                sweep_end_next  = top_base + ROW_SPAN;
            end
            else
                row_next = row_reg + RW'(1);
        end
        else if (ctl.col_zero)
            col_next = '0;
        else if (ctl.put_write)
            col_next = col_reg + CW'(1);
        else if (ctl.sweep_step)
            sweep_addr_next = sweep_addr_reg + AW'(1);

        out_valid_next = out_valid_reg;
        if (ctl.out_load)
            out_valid_next = 1'b1;
        else if (resp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            top_reg        <= '0;
            sweep_addr_reg <= '0;
            sweep_end_reg  <= LAST_CELL;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            top_reg        <= top_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_end_reg  <= sweep_end_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // item capture and result payload
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            char_reg     <= cmd_payload.char_code;
            rd_row_reg   <= RW'(cmd_payload.read_row);
            rd_col_reg   <= CXW'(cmd_payload.read_col);
            in_range_reg <= (32'(cmd_payload.read_row) < ROWS) &&
                            (32'(cmd_payload.read_col) < COLUMNS);
        end
        if (ctl.out_load)
        begin
            out_item_reg.cell_char  <= (ctl.cell_sel && in_range_reg) ? rd_data_reg : '0;
            out_item_reg.cursor_col <= RCOL_W'(col_next);
            out_item_reg.cursor_row <= RROW_W'(row_next);
        end
    end

    // screen memory, one port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (ctl.read)
            rd_data_reg <= mem[mem_addr];
    end

    assign resp.valid   = out_valid_reg;
    assign resp.payload = out_item_reg;

endmodule

// ----- rtl/text_terminal_writer_unit.sv -----
// Text terminal writer: one item in at a time, one result item out for each.
// CR, newline without scroll and func 3 answer from idle; a put passes through S_PUT;
// a read through S_READ and S_RDONE; a scroll sweeps one row, clear the whole screen.
// The single screen memory port handles one cell per cycle.
// Reset (rst_n low, async) homes the cursor, then a sweep fills the screen
// with spaces while no item is accepted.
`timescale 1ns / 1ps

module text_terminal_writer_unit #(
    parameter int COLUMNS = ttw_pkg::DEF_COLUMNS,
    parameter int ROWS    = ttw_pkg::DEF_ROWS
) (
    input  logic      clk,
    input  logic      rst_n,
    ttw_in_if.sink    cmd,
    ttw_out_if.source resp
);
    import ttw_pkg::*;

    // Structure
    //   ttw_ctrl     : one-hot sequencer. Decodes the accepted item and steps
    //                  through put, scroll sweep, clear sweep or read.
    //   ttw_datapath : cursor, scroll offset (top row pointer), sweep counter,
    //                  screen memory and result register.
    //
    // Scrolling does not move the store: the top row pointer advances and the
    // old top row, now the bottom, is swept to spaces one cell a cycle.
    // A deferred wrap (column == COLUMNS) is resolved when the next printable
    // char arrives, before it is written.
    //
    // cmd.ready is high only while the sequencer is idle and the result
    // register is empty or draining, so an item in flight always has a free
    // result slot when it finishes.

    ttw_ctl_t    ctl;
    ttw_status_t st;

    ttw_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd.valid),
        .cmd_payload (cmd.payload),
        .cmd_ready   (cmd.ready),
        .st          (st),
        .ctl         (ctl)
    );

    ttw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_payload (cmd.payload),
        .ctl         (ctl),
        .st          (st),
        .resp        (resp)
    );

endmodule

// ----- rtl/ttw_checker.sv -----
// Port-level checks of the text terminal writer, bound to the top level.
// Depends on ttw_pkg and text_terminal_writer_unit_macros.svh.
`timescale 1ns / 1ps
`include "text_terminal_writer_unit_macros.svh"

module ttw_checker #(
    parameter int COLUMNS = ttw_pkg::DEF_COLUMNS,
    parameter int ROWS    = ttw_pkg::DEF_ROWS
) (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input ttw_pkg::ttw_in_t  cmd_payload,
    input logic              resp_valid,
    input logic              resp_ready,
    input ttw_pkg::ttw_out_t resp_payload
);
    import ttw_pkg::*;

    logic cmd_acc;
    logic acc_unused;
    logic acc_return;

    assign cmd_acc    = cmd_valid && cmd_ready;
    assign acc_unused = cmd_acc && (cmd_payload.func == FUNC_NONE);
    assign acc_return = cmd_acc && (cmd_payload.func == FUNC_PUT) &&
                        (cmd_payload.char_code == CH_RETURN);

    // cursor never runs past the wrap position
    `TTW_ASSERT_IMPLY(a_col_range, resp_valid, (COLUMNS > 127) || (resp_payload.cursor_col <= COLUMNS))
    // unused code answers at once with no cell
    `TTW_ASSERT_NEXT(a_unused_now, acc_unused, resp_valid && (resp_payload.cell_char == '0))
    // carriage return answers at once at column zero
    `TTW_ASSERT_NEXT(a_return_now, acc_return, resp_valid && (resp_payload.cursor_col == '0))
    // a stalled result holds
    `TTW_ASSERT_NEXT(a_resp_hold, resp_valid && !resp_ready, resp_valid && $stable(resp_payload))

endmodule

bind text_terminal_writer_unit ttw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_ttw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .cmd_payload  (cmd.payload),
    .resp_valid   (resp.valid),
    .resp_ready   (resp.ready),
    .resp_payload (resp.payload)
);
